// ===== rtl/rme_pkg.sv =====
// Shared types, constants and helper functions for the register machine execute unit.
// Depends on nothing; every other file in rtl/ imports this package.
package rme_pkg;

    localparam int XLEN        = 32;
    localparam int PC_W        = 16;
    localparam int FUNC_W      = 5;
    localparam int REG_AW      = 4;              // register fields are 4 bits wide
    localparam int REG_COUNT   = 1 << REG_AW;
    localparam int DATA_BASE   = 1024;
    localparam int ADDR_BITS   = 16;
    localparam int MEM_WORDS   = 1 << ADDR_BITS;
    localparam int SUM_W       = ((ADDR_BITS > 16) ? ADDR_BITS : 16) + 1;
    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 56;

    typedef enum logic [FUNC_W-1:0] {
        OP_NOOP  = 5'd0,
        OP_LDI   = 5'd1,
        OP_ADD   = 5'd2,
        OP_SUB   = 5'd3,
        OP_MUL   = 5'd4,
        OP_AND   = 5'd5,
        OP_OR    = 5'd6,
        OP_NOT   = 5'd7,
        OP_LSL   = 5'd8,
        OP_LSR   = 5'd9,
        OP_CMP   = 5'd10,
        OP_JNE   = 5'd11,
        OP_JEQ   = 5'd12,
        OP_LOAD  = 5'd13,
        OP_STW   = 5'd14,
        OP_PRINT = 5'd15,
        OP_HALT  = 5'd16
    } op_t;

    // last field in the lowest bits
    typedef struct packed {
        logic [PC_W-1:0]   jump_target;
        logic [15:0]       imm;
        logic [REG_AW-1:0] src_b;
        logic [REG_AW-1:0] src_a;
        logic [REG_AW-1:0] dest_reg;
        logic [FUNC_W-1:0] func;
    } instr_t;

    typedef struct packed {
        logic            bad_op;
        logic            halted;
        logic [XLEN-1:0] print_value;
        logic            print_valid;
        logic [PC_W-1:0] pc_next;
    } result_t;

    // register file write port, including the status flag (bit 0 of register 0)
    typedef struct packed {
        logic              en;
        logic [REG_AW-1:0] addr;
        logic [XLEN-1:0]   data;
        logic              flag_en;
        logic              flag_val;
    } rf_wr_t;

    function automatic logic [ADDR_BITS-1:0] data_addr(input logic [15:0] imm);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(imm) + SUM_W'(DATA_BASE);
        return sum[ADDR_BITS-1:0];
    endfunction

    // read port 0 serves the in-place and single-register ops from dest_reg
    function automatic logic [REG_AW-1:0] rport0_addr(input instr_t ins);
        logic use_dest;
        use_dest = ins.func inside {OP_NOT, OP_LSL, OP_LSR, OP_CMP, OP_STW, OP_PRINT};
        return use_dest ? ins.dest_reg : ins.src_a;
    endfunction

    function automatic logic [REG_AW-1:0] rport1_addr(input instr_t ins);
        return (ins.func == OP_CMP) ? ins.src_a : ins.src_b;
    endfunction

endpackage

// ===== rtl/register_machine_execute_unit.sv =====
// Top level of the register machine execute unit: operand read, execute, data memory, result.
// Depends on rme_pkg and rme_regfile.
// Each accepted instruction passes the execute register, then the output register.
// Throughput: one instruction per cycle while the output is not stalled; operands come
// from the register file and data memory read ports issued at acceptance, with one-deep
// write forwarding. Reset: registers, PC and halt state clear at once; the data memory
// is then cleared over all 65536 words (one word per cycle) while s_tready stays low.
module register_machine_execute_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // func[4:0], dest_reg[8:5], src_a[12:9], src_b[16:13], imm[32:17], jump_target[48:33]
    input  logic [rme_pkg::IN_TDATA_W-1:0]   s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // pc_next[15:0], print_valid[16], print_value[48:17], halted[49], bad_op[50]
    output logic [rme_pkg::OUT_TDATA_W-1:0]  m_tdata
);
    import rme_pkg::*;

    localparam int INSTR_W  = $bits(instr_t);
    localparam int RESULT_W = $bits(result_t);

    logic [ADDR_BITS:0]    clr_cnt_reg;
    logic                  clearing;

    logic                  x_vld_reg, x_vld_next;
    instr_t                x_instr_reg;
    instr_t                s_instr, rd_instr;
    logic                  s_fire, x_fire;

    logic [PC_W-1:0]       pc_reg, pc_next;
    logic                  stop_reg, stop_next;

    logic                  m_vld_reg, m_vld_next;
    logic [OUT_TDATA_W-1:0] m_data_reg;

    logic [XLEN-1:0]       dmem [MEM_WORDS];
    logic [XLEN-1:0]       dmem_q_reg;
    logic                  st_vld_reg;
    logic [ADDR_BITS-1:0]  st_addr_reg;
    logic [XLEN-1:0]       st_data_reg;
    logic [ADDR_BITS-1:0]  x_addr, rd_addr;
    logic                  dm_we;
    logic [ADDR_BITS-1:0]  dm_waddr;
    logic [XLEN-1:0]       dm_wdata;
    logic [XLEN-1:0]       load_data;

    logic [XLEN-1:0]       ra, rb;
    logic                  flag;
    rf_wr_t                rf_wr;
    logic                  rf_we, st_en, flag_en, flag_val;
    logic [XLEN-1:0]       rf_wdata;
    result_t               res;

    assign clearing = !clr_cnt_reg[ADDR_BITS];
    assign s_instr  = instr_t'(s_tdata[INSTR_W-1:0]);
    assign x_fire   = x_vld_reg && (!m_vld_reg || m_tready);
    assign s_tready = !clearing && (!x_vld_reg || x_fire);
    assign s_fire   = s_tvalid && s_tready;

    // while the execute stage holds, keep reading for it so its operands stay current
    assign rd_instr = s_fire ? s_instr : x_instr_reg;
    assign rd_addr  = data_addr(rd_instr.imm);
    assign x_addr   = data_addr(x_instr_reg.imm);

    rme_regfile u_regfile (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_addr0 (rport0_addr(rd_instr)),
        .rd_addr1 (rport1_addr(rd_instr)),
        .rd_data0 (ra),
        .rd_data1 (rb),
        .wr       (rf_wr),
        .flag     (flag)
    );

    assign load_data = (st_vld_reg && st_addr_reg == x_addr) ? st_data_reg : dmem_q_reg;

    always_comb
    begin
        rf_we    = 1'b0;
        rf_wdata = '0;
        st_en    = 1'b0;
        flag_en  = 1'b0;
        flag_val = 1'b0;
        pc_next  = pc_reg + PC_W'(1);
        stop_next = stop_reg;
        res      = '0;
        if (stop_reg)
        begin
            pc_next = pc_reg;
        end
        else
        begin
            case (x_instr_reg.func)
                OP_NOOP:  ;
                OP_LDI:   begin rf_we = 1'b1; rf_wdata = XLEN'(x_instr_reg.imm); end
                OP_ADD:   begin rf_we = 1'b1; rf_wdata = ra + rb; end
                OP_SUB:   begin rf_we = 1'b1; rf_wdata = ra - rb; end
                OP_MUL:   begin rf_we = 1'b1; rf_wdata = ra * rb; end
                OP_AND:   begin rf_we = 1'b1; rf_wdata = ra & rb; end
                OP_OR:    begin rf_we = 1'b1; rf_wdata = ra | rb; end
                OP_NOT:   begin rf_we = 1'b1; rf_wdata = ~ra; end
                OP_LSL:   begin rf_we = 1'b1; rf_wdata = {ra[XLEN-2:0], 1'b0}; end
                OP_LSR:   begin rf_we = 1'b1; rf_wdata = {1'b0, ra[XLEN-1:1]}; end
                OP_CMP:   begin flag_en = 1'b1; flag_val = (ra == rb); end
                OP_JNE:
                begin
                    if (!flag)
                    begin
                        pc_next = x_instr_reg.jump_target;
                    end
                end
                OP_JEQ:
                begin
                    if (flag)
                    begin
                        pc_next = x_instr_reg.jump_target;
                    end
                end
                OP_LOAD:  begin rf_we = 1'b1; rf_wdata = load_data; end
                OP_STW:   st_en = 1'b1;
                OP_PRINT: begin res.print_valid = 1'b1; res.print_value = ra; end
                OP_HALT:  begin stop_next = 1'b1; pc_next = pc_reg; end
                default:
                begin
                    stop_next  = 1'b1;
                    res.bad_op = 1'b1;
                    pc_next    = pc_reg;
                end
            endcase
        end
        res.pc_next = pc_next;
        res.halted  = stop_next;
    end

    assign rf_wr.en       = x_fire && rf_we;
    assign rf_wr.addr     = x_instr_reg.dest_reg;
    assign rf_wr.data     = rf_wdata;
    assign rf_wr.flag_en  = x_fire && flag_en;
    assign rf_wr.flag_val = flag_val;

    assign dm_we    = clearing || (x_fire && st_en);
    assign dm_waddr = clearing ? clr_cnt_reg[ADDR_BITS-1:0] : x_addr;
    assign dm_wdata = clearing ? '0 : ra;

    always_ff @(posedge clk)
    begin
        if (dm_we)
        begin
            dmem[dm_waddr] <= dm_wdata;
        end
        dmem_q_reg <= dmem[rd_addr];
        if (x_fire && st_en)
        begin
            st_addr_reg <= x_addr;
            st_data_reg <= ra;
        end
        if (s_fire)
        begin
            x_instr_reg <= s_instr;
        end
        if (x_fire)
        begin
            m_data_reg <= OUT_TDATA_W'(RESULT_W'(res));
        end
    end

    assign x_vld_next = s_fire ? 1'b1 : (x_fire ? 1'b0 : x_vld_reg);
    assign m_vld_next = x_fire ? 1'b1 : (m_tready ? 1'b0 : m_vld_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
            x_vld_reg   <= 1'b0;
            m_vld_reg   <= 1'b0;
            pc_reg      <= '0;
            stop_reg    <= 1'b0;
            st_vld_reg  <= 1'b0;
        end
        else
        begin
            if (clearing)
            begin
                clr_cnt_reg <= clr_cnt_reg + (ADDR_BITS + 1)'(1);
            end
            x_vld_reg <= x_vld_next;
            m_vld_reg <= m_vld_next;
            if (x_fire)
            begin
                pc_reg   <= pc_next;
                stop_reg <= stop_next;
                if (st_en && !stop_reg)
                begin
                    st_vld_reg <= 1'b1;
                end
            end
        end
    end

    assign m_tvalid = m_vld_reg;
    assign m_tdata  = m_data_reg;

endmodule

// ===== rtl/rme_regfile.sv =====
// Register file: 16 x 32 synchronous memory, two registered read ports, one write port.
// Adds reset valid bits, last-write forwarding and the status flag overlay. Uses rme_pkg.
module rme_regfile (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [rme_pkg::REG_AW-1:0]  rd_addr0,
    input  logic [rme_pkg::REG_AW-1:0]  rd_addr1,
    output logic [rme_pkg::XLEN-1:0]    rd_data0,
    output logic [rme_pkg::XLEN-1:0]    rd_data1,
    input  rme_pkg::rf_wr_t             wr,
    output logic                        flag
);
    import rme_pkg::*;

    logic [XLEN-1:0]      regs_mem [REG_COUNT];
    logic [REG_COUNT-1:0] vld_reg, vld_next;
    logic [XLEN-1:0]      q0_reg, q1_reg;
    logic                 v0_reg, v1_reg;
    logic [REG_AW-1:0]    a0_reg, a1_reg;
    logic                 fwd_vld_reg;
    logic [REG_AW-1:0]    fwd_addr_reg;
    logic [XLEN-1:0]      fwd_data_reg;
    logic                 flag_reg, flag_next;
    logic [XLEN-1:0]      word0, word1;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            regs_mem[wr.addr] <= wr.data;
        end
        q0_reg <= regs_mem[rd_addr0];
        q1_reg <= regs_mem[rd_addr1];
        v0_reg <= vld_reg[rd_addr0];
        v1_reg <= vld_reg[rd_addr1];
        a0_reg <= rd_addr0;
        a1_reg <= rd_addr1;
        if (wr.en)
        begin
            fwd_addr_reg <= wr.addr;
            fwd_data_reg <= wr.data;
        end
    end

    always_comb
    begin
        vld_next = vld_reg;
        if (wr.en)
        begin
            vld_next[wr.addr] = 1'b1;
        end
        flag_next = flag_reg;
        if (wr.flag_en)
        begin
            flag_next = wr.flag_val;
        end
        else if (wr.en && (wr.addr == '0))
        begin
            flag_next = wr.data[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            fwd_vld_reg <= 1'b0;
            flag_reg    <= 1'b0;
        end
        else
        begin
            vld_reg  <= vld_next;
            flag_reg <= flag_next;
            if (wr.en)
            begin
                fwd_vld_reg <= 1'b1;
            end
        end
    end

    // the forward register always holds the most recent write, so a match is never stale
    assign word0 = (fwd_vld_reg && fwd_addr_reg == a0_reg) ? fwd_data_reg
                 : (v0_reg ? q0_reg : '0);
    assign word1 = (fwd_vld_reg && fwd_addr_reg == a1_reg) ? fwd_data_reg
                 : (v1_reg ? q1_reg : '0);

    // bit 0 of register 0 lives in flag_reg
    assign rd_data0 = (a0_reg == '0) ? {word0[XLEN-1:1], flag_reg} : word0;
    assign rd_data1 = (a1_reg == '0) ? {word1[XLEN-1:1], flag_reg} : word1;
    assign flag     = flag_reg;

endmodule

// ===== rtl/rme_checker.sv =====
// Port-level checker for register_machine_execute_unit, attached by the bind at the end.
// Depends on rme_pkg for the bus widths.
module rme_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic [rme_pkg::OUT_TDATA_W-1:0]  m_tdata
);
    import rme_pkg::*;

    logic [1:0]      inflight_reg;
    logic            seen_halt_reg;
    logic [PC_W-1:0] halt_pc_reg;
    logic            s_fire, m_fire;
    result_t         res;

    assign s_fire = s_tvalid && s_tready;
    assign m_fire = m_tvalid && m_tready;
    assign res    = result_t'(m_tdata[$bits(result_t)-1:0]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inflight_reg  <= '0;
            seen_halt_reg <= 1'b0;
            halt_pc_reg   <= '0;
        end
        else
        begin
            inflight_reg <= inflight_reg + 2'(s_fire) - 2'(m_fire);
            if (m_fire && res.halted && !seen_halt_reg)
            begin
                seen_halt_reg <= 1'b1;
                halt_pc_reg   <= res.pc_next;
            end
        end
    end

    // execute stage plus output register: never more than two transactions in flight
    a_inflight_bound: assert property (@(posedge clk) disable iff (!rst_n)
        inflight_reg != 2'd3)
        else $error("more than two transactions in flight");

    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> inflight_reg != 2'd0)
        else $error("result without an accepted instruction");

    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && seen_halt_reg) |->
            (res.halted && res.pc_next == halt_pc_reg && !res.print_valid && !res.bad_op))
        else $error("result after halt is not the held state");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed");

endmodule

bind register_machine_execute_unit rme_checker u_rme_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
